// ===== hdl/icl_pkg.sv =====
// ----------------------------------------------------------------------------
// icl_pkg
// Types, constants and character helpers for the interface counter line
// parser.
// ----------------------------------------------------------------------------
package icl_pkg;

  localparam int NAME_LIMIT  = 64;
  localparam int FIELD_LIMIT = 16;

  localparam int NAME_LEN_W  = $clog2(NAME_LIMIT + 1);
  localparam int FIELD_IDX_W = $clog2(FIELD_LIMIT + 1);
  localparam int CNT_W       = 64;

  // Counter positions that feed the results, and the minimum count for a valid line.
  localparam int RX_FIELD   = 0;
  localparam int TX_FIELD   = 8;
  localparam int MIN_FIELDS = 9;
  localparam int LO_LENGTH  = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;

  localparam logic KIND_LINE   = 1'b0;
  localparam logic KIND_TOTALS = 1'b1;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_NAME,
    PH_SEP,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    LO_NONE,
    LO_L,
    LO_LO,
    LO_MISS
  } lo_match_t;

  typedef struct packed {
    logic             kind;
    logic             ok;
    logic [CNT_W-1:0] rx_value;
    logic [CNT_W-1:0] tx_value;
    logic             loopback;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

  typedef struct packed {
    phase_t phase;
    logic   line_pending;
    logic   overflow;
  } parser_status_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
  } fifo_status_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== hdl/icl_if.sv =====
// ----------------------------------------------------------------------------
// icl_if
// Valid/ready channels for text bytes in and parser results out.
// ----------------------------------------------------------------------------
interface icl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_file;

  modport source (output valid, output ch, output end_of_file, input ready);
  modport sink   (input valid, input ch, input end_of_file, output ready);
endinterface

interface icl_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        ok;
  logic [63:0] rx_value;
  logic [63:0] tx_value;
  logic        loopback;
  logic        last;

  modport source (output valid, output kind, output ok, output rx_value, output tx_value,
                  output loopback, output last, input ready);
  modport sink   (input valid, input kind, input ok, input rx_value, input tx_value,
                  input loopback, input last, output ready);
endinterface

// ===== hdl/icl_parser.sv =====
// ----------------------------------------------------------------------------
// icl_parser
// Per-byte line state, decimal accumulation and running totals. Produces
// zero, one or two result items for each accepted item.
// ----------------------------------------------------------------------------
module icl_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic [7:0]              ch,
  input  logic                    end_of_file,
  output icl_pkg::push_t          push,
  output icl_pkg::parser_status_t status
);
  import icl_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [NAME_LEN_W-1:0]  name_len_r, name_len_nxt;
  logic [NAME_LEN_W-1:0]  trim_len_r, trim_len_nxt;
  lo_match_t              lo_r, lo_nxt;
  logic [FIELD_IDX_W-1:0] fidx_r, fidx_nxt;
  logic [CNT_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       first_r, first_nxt;
  logic [CNT_W-1:0]       ninth_r, ninth_nxt;
  logic                   pending_r, pending_nxt;
  logic [CNT_W-1:0]       rx_tot_r, rx_tot_nxt;
  logic [CNT_W-1:0]       tx_tot_r, tx_tot_nxt;
  logic                   ovf_r, ovf_nxt;

  logic                   c_nl, c_blank, c_space, c_digit, c_colon;
  logic [3:0]             digit;
  logic [FIELD_IDX_W-1:0] close_fidx;
  logic [CNT_W-1:0]       close_first, close_ninth;
  logic [CNT_W+3:0]       acc_prod;
  logic [CNT_W-1:0]       acc_step;
  logic [NAME_LEN_W-1:0]  name_len_inc;
  lo_match_t              lo_byte;
  logic [NAME_LEN_W-1:0]  trim_len_byte;
  logic [FIELD_IDX_W-1:0] eff_fidx;
  logic [CNT_W-1:0]       eff_first, eff_ninth;
  logic                   colon_seen, line_valid, line_lo, do_line, add_en, add_ovf;
  logic [CNT_W:0]         rx_sum, tx_sum;
  logic                   ovf_line;
  logic [CNT_W-1:0]       rx_line, tx_line;
  result_t                line_res, tot_res;

  // Byte decode and helpers shared by the phase logic and the datapath.
  always_comb begin
    c_nl    = (ch == CH_NL);
    c_blank = is_blank(ch);
    c_space = is_space(ch);
    c_digit = is_digit(ch);
    c_colon = (ch == CH_COLON);
    digit   = ch[3:0];

    close_fidx  = (fidx_r < FIELD_IDX_W'(FIELD_LIMIT)) ? fidx_r + 1'b1 : fidx_r;
    close_first = (fidx_r == FIELD_IDX_W'(RX_FIELD)) ? acc_r : first_r;
    close_ninth = (fidx_r == FIELD_IDX_W'(TX_FIELD)) ? acc_r : ninth_r;

    // acc * 10 + digit, saturating when anything spills past 64 bits.
    acc_prod = {acc_r, 3'b000} + {1'b0, acc_r, 1'b0} + (CNT_W+4)'(digit);
    acc_step = (|acc_prod[CNT_W+3:CNT_W]) ? '1 : acc_prod[CNT_W-1:0];

    name_len_inc = (name_len_r < NAME_LEN_W'(NAME_LIMIT)) ? name_len_r + 1'b1 : name_len_r;
    if (name_len_r == '0) begin
      lo_byte = (ch == CH_L) ? LO_L : LO_MISS;
    end else if (name_len_r == NAME_LEN_W'(1)) begin
      lo_byte = (lo_r == LO_L && ch == CH_O) ? LO_LO : LO_MISS;
    end else begin
      lo_byte = lo_r;
    end
    trim_len_byte = c_blank ? trim_len_r : name_len_inc;
  end

  // Line close: evaluation, totals update and the result items.
  always_comb begin
    eff_fidx  = (phase_r == PH_DIGIT) ? close_fidx  : fidx_r;
    eff_first = (phase_r == PH_DIGIT) ? close_first : first_r;
    eff_ninth = (phase_r == PH_DIGIT) ? close_ninth : ninth_r;

    colon_seen = (phase_r == PH_SEP) || (phase_r == PH_DIGIT) || (phase_r == PH_DONE);
    line_valid = colon_seen && (trim_len_r != '0) &&
                 (trim_len_r < NAME_LEN_W'(NAME_LIMIT)) &&
                 (eff_fidx >= FIELD_IDX_W'(MIN_FIELDS));
    line_lo    = colon_seen && (lo_r == LO_LO) && (trim_len_r == NAME_LEN_W'(LO_LENGTH));

    do_line = fire && (end_of_file ? pending_r : c_nl);
    add_en  = do_line && line_valid && !line_lo && !ovf_r;
    rx_sum  = {1'b0, rx_tot_r} + {1'b0, eff_first};
    tx_sum  = {1'b0, tx_tot_r} + {1'b0, eff_ninth};
    add_ovf = rx_sum[CNT_W] || tx_sum[CNT_W];

    ovf_line = ovf_r || (add_en && add_ovf);
    rx_line  = (add_en && !add_ovf) ? rx_sum[CNT_W-1:0] : rx_tot_r;
    tx_line  = (add_en && !add_ovf) ? tx_sum[CNT_W-1:0] : tx_tot_r;

    line_res.kind     = KIND_LINE;
    line_res.ok       = line_valid;
    line_res.rx_value = line_valid ? eff_first : '0;
    line_res.tx_value = line_valid ? eff_ninth : '0;
    line_res.loopback = line_lo;
    line_res.last     = !end_of_file;

    tot_res.kind     = KIND_TOTALS;
    tot_res.ok       = !ovf_line;
    tot_res.rx_value = ovf_line ? '0 : rx_line;
    tot_res.tx_value = ovf_line ? '0 : tx_line;
    tot_res.loopback = 1'b0;
    tot_res.last     = 1'b1;

    push.res1 = tot_res;
    if (fire && end_of_file) begin
      push.count = pending_r ? 2'd2 : 2'd1;
      push.res0  = pending_r ? line_res : tot_res;
    end else if (fire && c_nl) begin
      push.count = 2'd1;
      push.res0  = line_res;
    end else begin
      push.count = 2'd0;
      push.res0  = line_res;
    end
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (end_of_file || c_nl) begin
        phase_nxt = PH_LEAD;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (c_colon) begin
              phase_nxt = PH_SEP;
            end else if (!c_blank) begin
              phase_nxt = PH_NAME;
            end
          end
          PH_NAME: begin
            if (c_colon) begin
              phase_nxt = PH_SEP;
            end
          end
          PH_SEP: begin
            if (c_digit) begin
              phase_nxt = PH_DIGIT;
            end else if (!c_space) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_DIGIT: begin
            if (!c_digit) begin
              phase_nxt = (c_space && close_fidx < FIELD_IDX_W'(FIELD_LIMIT)) ? PH_SEP : PH_DONE;
            end
          end
          default: phase_nxt = PH_DONE;
        endcase
      end
    end
  end

  // Line datapath and totals.
  always_comb begin
    name_len_nxt = name_len_r;
    trim_len_nxt = trim_len_r;
    lo_nxt       = lo_r;
    fidx_nxt     = fidx_r;
    acc_nxt      = acc_r;
    first_nxt    = first_r;
    ninth_nxt    = ninth_r;
    pending_nxt  = pending_r;
    rx_tot_nxt   = rx_tot_r;
    tx_tot_nxt   = tx_tot_r;
    ovf_nxt      = ovf_r;

    if (fire) begin
      if (end_of_file || c_nl) begin
        name_len_nxt = '0;
        trim_len_nxt = '0;
        lo_nxt       = LO_NONE;
        fidx_nxt     = '0;
        acc_nxt      = '0;
        first_nxt    = '0;
        ninth_nxt    = '0;
        pending_nxt  = 1'b0;
      end else begin
        pending_nxt = 1'b1;
        case (phase_r)
          PH_LEAD, PH_NAME: begin
            if (!c_colon && !(phase_r == PH_LEAD && c_blank)) begin
              name_len_nxt = name_len_inc;
              trim_len_nxt = trim_len_byte;
              lo_nxt       = lo_byte;
            end
          end
          PH_SEP: begin
            if (c_digit) begin
              acc_nxt = CNT_W'(digit);
            end
          end
          PH_DIGIT: begin
            if (c_digit) begin
              acc_nxt = acc_step;
            end else begin
              fidx_nxt  = close_fidx;
              first_nxt = close_first;
              ninth_nxt = close_ninth;
              acc_nxt   = '0;
            end
          end
          default: ;
        endcase
      end

      if (end_of_file) begin
        rx_tot_nxt = '0;
        tx_tot_nxt = '0;
        ovf_nxt    = 1'b0;
      end else begin
        rx_tot_nxt = rx_line;
        tx_tot_nxt = tx_line;
        ovf_nxt    = ovf_line;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      name_len_r <= '0;
      trim_len_r <= '0;
      lo_r       <= LO_NONE;
      fidx_r     <= '0;
      acc_r      <= '0;
      first_r    <= '0;
      ninth_r    <= '0;
      pending_r  <= 1'b0;
      rx_tot_r   <= '0;
      tx_tot_r   <= '0;
      ovf_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      name_len_r <= name_len_nxt;
      trim_len_r <= trim_len_nxt;
      lo_r       <= lo_nxt;
      fidx_r     <= fidx_nxt;
      acc_r      <= acc_nxt;
      first_r    <= first_nxt;
      ninth_r    <= ninth_nxt;
      pending_r  <= pending_nxt;
      rx_tot_r   <= rx_tot_nxt;
      tx_tot_r   <= tx_tot_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  assign status.phase        = phase_r;
  assign status.line_pending = pending_r;
  assign status.overflow     = ovf_r;

endmodule

// ===== hdl/icl_out_fifo.sv =====
// ----------------------------------------------------------------------------
// icl_out_fifo
// Small result queue: takes up to two items per cycle from the parser and
// hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module icl_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  icl_pkg::push_t        push,
  input  logic                  pop,
  output logic                  out_valid,
  output icl_pkg::result_t      out_data,
  output icl_pkg::fifo_status_t status
);
  import icl_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_pop;
  logic [FIFO_PTR_W-1:0] wr_ptr_second;

  always_comb begin
    do_pop        = pop && (count_r != '0);
    wr_ptr_second = wr_ptr_r + 1'b1;
    wr_ptr_nxt    = wr_ptr_r + FIFO_PTR_W'(push.count);
    rd_ptr_nxt    = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt     = count_r + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_second] <= push.res1;
    end
  end

  assign out_valid    = (count_r != '0);
  assign out_data     = mem_r[rd_ptr_r];
  assign status.count = count_r;

endmodule

// ===== hdl/interface_counter_line_parser.sv =====
// ----------------------------------------------------------------------------
// interface_counter_line_parser
// Parses interface counter text one byte per cycle while input ready is high, and
// reports per-line receive/transmit counters and end-of-file totals.
// ----------------------------------------------------------------------------
//   channel   | dir | payload                                          | handshake
//   in_chan   | in  | ch[7:0], end_of_file                             | valid/ready
//   out_chan  | out | kind, ok, rx_value[63:0], tx_value[63:0],        | valid/ready
//             |     | loopback, last                                   |
//
// One byte is accepted per cycle while input ready is high; at that edge its line
// state updates and its results enter the output queue behind any items it holds.
// A newline gives one item; end of file one or two, drained one per ready cycle.
// Input ready holds while the four-entry result queue has room for two items.
// Reset is synchronous, active low, and clears the line state and the totals.
module interface_counter_line_parser (
  input  logic      clk,
  input  logic      rst_n,
  icl_in_if.sink    in_chan,
  icl_out_if.source out_chan
);
  import icl_pkg::*;

  logic           in_fire;
  push_t          push;
  parser_status_t p_status;
  fifo_status_t   f_status;
  result_t        out_data;
  logic           out_valid;

  assign in_chan.ready = (f_status.count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_fire       = in_chan.valid && in_chan.ready;

  icl_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (in_fire),
    .ch          (in_chan.ch),
    .end_of_file (in_chan.end_of_file),
    .push        (push),
    .status      (p_status)
  );

  icl_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_chan.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (f_status)
  );

  assign out_chan.valid    = out_valid;
  assign out_chan.kind     = out_data.kind;
  assign out_chan.ok       = out_data.ok;
  assign out_chan.rx_value = out_data.rx_value;
  assign out_chan.tx_value = out_data.tx_value;
  assign out_chan.loopback = out_data.loopback;
  assign out_chan.last     = out_data.last;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    f_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue holds more items than its depth");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_file |=>
      p_status.phase == PH_LEAD && !p_status.line_pending && !p_status.overflow)
    else $error("end of file did not return the parser to a fresh sample");

  a_byte_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_chan.end_of_file && in_chan.ch != CH_NL |=> p_status.line_pending)
    else $error("text byte did not open a pending line");
`endif

endmodule
